// ===== src/two_level_page_table_manager_macros.svh =====
// Assertion macros for the two-level page table manager checker.
// No dependencies; included by the checker file.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TLPTM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlptm: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define TLPTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlptm: next-cycle check failed");

`endif

// ===== src/tlptm_pkg.sv =====
// Shared types and constants of the two-level page table manager.
// No dependencies; used by the sequencer, the top level and the checker.
`timescale 1ns / 1ps

package tlptm_pkg;

    localparam int DIR_AW          = 10;
    localparam int TBL_AW          = 10;
    localparam int OFF_W           = 12;
    localparam int FRAME_W         = 20;
    localparam int TBL_ENTRIES     = 1 << TBL_AW;
    localparam int TABLE_SLOTS_DEF = 16;

    // request kinds
    localparam logic [1:0] K_TRANSLATE = 2'd0;
    localparam logic [1:0] K_MAP       = 2'd1;
    localparam logic [1:0] K_UNMAP     = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_TABLE   = 3'd1;
    localparam logic [2:0] ST_ABSENT     = 3'd2;
    localparam logic [2:0] ST_POOL_FULL  = 3'd3;
    localparam logic [2:0] ST_MAPPED     = 3'd4;
    localparam logic [2:0] ST_ZERO_FRAME = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        virt_addr;
        logic [FRAME_W-1:0] frame;
        logic               writeable;
        logic               kernel_only;
        logic               release_frame;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        phys_addr;
        logic               page_writeable;
        logic               page_user;
        logic               dir_writeable;
        logic               dir_user;
        logic [FRAME_W-1:0] freed_frame;
        logic               freed_valid;
    } t_res;

    // page table entry as stored in the table memory
    typedef struct packed {
        logic               user;
        logic               rw;
        logic               present;
        logic [FRAME_W-1:0] frame;
    } t_pte;

    localparam int PTE_W = $bits(t_pte);

endpackage

// ===== src/tlptm_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; used for the directory and the page table store.
`timescale 1ns / 1ps

module tlptm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/tlptm_ctrl.sv =====
// Request sequencer: clearing pass, directory lookup, table read-modify-write.
// Depends on tlptm_pkg; drives the two tlptm_ram instances in the top level.
`timescale 1ns / 1ps

module tlptm_ctrl #(
    parameter int TABLE_SLOTS = tlptm_pkg::TABLE_SLOTS_DEF,
    parameter int SLOT_W      = 4,
    parameter int PAGE_AW     = 14,
    parameter int DIR_W       = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  tlptm_pkg::t_req             i_req,
    output logic                        o_req_stall,
    input  logic                        i_out_free,
    output logic                        o_res_valid,
    output tlptm_pkg::t_res             o_res,
    output logic                        o_dir_we,
    output logic [tlptm_pkg::DIR_AW-1:0] o_dir_addr,
    output logic [DIR_W-1:0]            o_dir_wdata,
    input  logic [DIR_W-1:0]            i_dir_rdata,
    output logic                        o_page_we,
    output logic [PAGE_AW-1:0]          o_page_addr,
    output logic [tlptm_pkg::PTE_W-1:0] o_page_wdata,
    input  logic [tlptm_pkg::PTE_W-1:0] i_page_rdata
);

    import tlptm_pkg::*;

    localparam logic [PAGE_AW-1:0] CLR_LAST = PAGE_AW'(TABLE_SLOTS * TBL_ENTRIES - 1);
    localparam logic [SLOT_W:0]    POOL_MAX = (SLOT_W + 1)'(TABLE_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIR,
        S_PAGE,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [PAGE_AW-1:0]  r_clr;
    logic [SLOT_W:0]     r_next_slot;
    t_req                r_req;
    logic [1:0]          r_dflags;
    logic [PAGE_AW-1:0]  r_page_addr;
    t_res                r_res;

    logic                q_present;
    logic [SLOT_W-1:0]   q_slot;
    logic [1:0]          q_flags;
    logic [1:0]          new_flags;
    logic [TBL_AW-1:0]   tbl_idx;
    t_pte                pe;
    t_pte                new_pe;
    logic                fin;
    logic                alloc;
    t_res                res;

    assign q_present = i_dir_rdata[DIR_W-1];
    assign q_slot    = i_dir_rdata[SLOT_W+1:2];
    assign q_flags   = i_dir_rdata[1:0];
    assign new_flags = {~r_req.kernel_only, r_req.writeable};
    assign tbl_idx   = r_req.virt_addr[OFF_W +: TBL_AW];
    assign pe        = t_pte'(i_page_rdata);

    always_comb begin
        new_pe         = '0;
        new_pe.user    = ~r_req.kernel_only;
        new_pe.rw      = r_req.writeable;
        new_pe.present = 1'b1;
        new_pe.frame   = r_req.frame;
    end

    always_comb begin
        fin          = 1'b0;
        alloc        = 1'b0;
        res          = '0;
        o_dir_we     = 1'b0;
        o_dir_addr   = r_req.virt_addr[31 -: DIR_AW];
        o_dir_wdata  = '0;
        o_page_we    = 1'b0;
        o_page_addr  = r_page_addr;
        o_page_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_dir_we    = 1'b1;
                o_dir_addr  = r_clr[DIR_AW-1:0];
                o_page_we   = 1'b1;
                o_page_addr = r_clr;
            end
            S_IDLE: begin
                o_dir_addr = i_req.virt_addr[31 -: DIR_AW];
            end
            S_DIR: begin
                case (r_req.kind) inside
                    K_TRANSLATE, K_UNMAP: begin
                        if (!q_present) begin
                            fin        = 1'b1;
                            res.status = ST_NO_TABLE;
                        end else begin
                            o_page_addr = {q_slot, tbl_idx};
                        end
                    end
                    K_MAP: begin
                        if (r_req.frame == '0) begin
                            fin        = 1'b1;
                            res.status = ST_ZERO_FRAME;
                        end else if (!q_present && r_next_slot >= POOL_MAX) begin
                            fin        = 1'b1;
                            res.status = ST_POOL_FULL;
                        end else if (!q_present) begin
                            // fresh slot: its table was zeroed by the reset pass
                            alloc       = 1'b1;
                            o_dir_we    = 1'b1;
                            o_dir_wdata = {1'b1, r_next_slot[SLOT_W-1:0], new_flags};
                            o_page_addr = {r_next_slot[SLOT_W-1:0], tbl_idx};
                        end else begin
                            o_page_addr = {q_slot, tbl_idx};
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_PAGE: begin
                fin               = 1'b1;
                res.dir_writeable = r_dflags[0];
                res.dir_user      = r_dflags[1];
                case (r_req.kind)
                    K_TRANSLATE: begin
                        if (!pe.present) begin
                            res.status = ST_ABSENT;
                        end else begin
                            res.phys_addr      = {pe.frame, r_req.virt_addr[OFF_W-1:0]};
                            res.page_writeable = pe.rw;
                            res.page_user      = pe.user;
                        end
                    end
                    K_MAP: begin
                        if (pe.present) begin
                            res.status         = ST_MAPPED;
                            res.page_writeable = pe.rw;
                            res.page_user      = pe.user;
                        end else begin
                            o_page_we          = 1'b1;
                            o_page_wdata       = new_pe;
                            res.page_writeable = new_pe.rw;
                            res.page_user      = new_pe.user;
                        end
                    end
                    K_UNMAP: begin
                        if (!pe.present) begin
                            res.status = ST_ABSENT;
                        end else begin
                            o_page_we = 1'b1;
                            if (r_req.release_frame) begin
                                res.freed_frame = pe.frame;
                                res.freed_valid = 1'b1;
                            end
                        end
                    end
                    default: begin
                        res = '0;
                    end
                endcase
            end
            S_HOLD: begin
                res = r_res;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = fin || (r_state == S_HOLD);
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_slot <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req   <= i_req;
                        r_state <= S_DIR;
                    end
                end
                S_DIR: begin
                    r_dflags    <= alloc ? new_flags : q_flags;
                    r_page_addr <= o_page_addr;
                    if (alloc) begin
                        r_next_slot <= r_next_slot + 1'b1;
                    end
                    if (fin) begin
                        r_res   <= res;
                        r_state <= i_out_free ? S_IDLE : S_HOLD;
                    end else begin
                        r_state <= S_PAGE;
                    end
                end
                S_PAGE: begin
                    r_res   <= res;
                    r_state <= i_out_free ? S_IDLE : S_HOLD;
                end
                S_HOLD: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/two_level_page_table_manager.sv =====
// Two-level page table manager: request sequencer, directory and table RAMs,
// result register. Depends on tlptm_pkg, tlptm_ram and tlptm_ctrl.
//
// Usage:
//   Requests enter on i_in / i_in_valid; the block raises o_in_stall while it
//   works on one, so one request is in flight at a time. Results leave on
//   o_out / o_out_valid, one beat per request, held while i_out_stall is high.
//   A request is decided in S_DIR, the directory read, when the directory
//   lookup alone settles it, else in S_PAGE, the table read, whose entry is
//   written back in that same cycle; the result then enters o_out's register.
//   The next request is taken the cycle after the result is handed to the
//   output register, so a full result register does not stop that request
//   being taken; a second finished result waits inside, with o_in_stall
//   high, until the first beat is taken.
//   After reset the block clears both RAMs, one entry a cycle, over the
//   TABLE_SLOTS * 1024 table entries (16384 at the default), o_in_stall high.
//   Table slots come from a bump pool and are never reused.
`timescale 1ns / 1ps

module two_level_page_table_manager #(
    parameter int TABLE_SLOTS = tlptm_pkg::TABLE_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tlptm_pkg::t_req i_in,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output tlptm_pkg::t_res o_out,
    input  logic            i_out_stall
);

    import tlptm_pkg::*;

    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int PAGE_AW = SLOT_W + TBL_AW;
    localparam int DIR_W   = SLOT_W + 3;

    logic                r_out_valid;
    t_res                r_out;
    logic                out_free;
    logic                res_valid;
    t_res                res;
    logic                dir_we;
    logic [DIR_AW-1:0]   dir_addr;
    logic [DIR_W-1:0]    dir_wdata;
    logic [DIR_W-1:0]    dir_rdata;
    logic                page_we;
    logic [PAGE_AW-1:0]  page_addr;
    logic [PTE_W-1:0]    page_wdata;
    logic [PTE_W-1:0]    page_rdata;

    assign out_free = !r_out_valid || !i_out_stall;

    tlptm_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W),
        .PAGE_AW     (PAGE_AW),
        .DIR_W       (DIR_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_in_valid),
        .i_req        (i_in),
        .o_req_stall  (o_in_stall),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .o_dir_we     (dir_we),
        .o_dir_addr   (dir_addr),
        .o_dir_wdata  (dir_wdata),
        .i_dir_rdata  (dir_rdata),
        .o_page_we    (page_we),
        .o_page_addr  (page_addr),
        .o_page_wdata (page_wdata),
        .i_page_rdata (page_rdata)
    );

    // directory word: {present, slot, user, rw}
    tlptm_ram #(
        .WIDTH (DIR_W),
        .DEPTH (1 << DIR_AW),
        .AW    (DIR_AW)
    ) u_dir_ram (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_addr  (dir_addr),
        .i_wdata (dir_wdata),
        .o_rdata (dir_rdata)
    );

    tlptm_ram #(
        .WIDTH (PTE_W),
        .DEPTH (TABLE_SLOTS * TBL_ENTRIES),
        .AW    (PAGE_AW)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (page_we),
        .i_addr  (page_addr),
        .i_wdata (page_wdata),
        .o_rdata (page_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= res_valid;
            end
            if (out_free && res_valid) begin
                r_out <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== src/tlptm_checker.sv =====
// Port-level checks for the two-level page table manager, bound to the top.
// Depends on tlptm_pkg and two_level_page_table_manager_macros.svh.
`timescale 1ns / 1ps
`include "two_level_page_table_manager_macros.svh"

module tlptm_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input tlptm_pkg::t_req i_in,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input tlptm_pkg::t_res o_out,
    input logic            i_out_stall
);

    import tlptm_pkg::*;

    // one request at a time: an accepted beat makes the block busy
    `TLPTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    `TLPTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // a freed frame or a nonzero address only comes with a successful request
    `TLPTM_ASSERT_IMPL(a_freed_ok, i_clk, i_rst_n, o_out_valid && o_out.freed_valid, o_out.status == ST_OK)

    `TLPTM_ASSERT_IMPL(a_phys_ok, i_clk, i_rst_n, o_out_valid && (o_out.phys_addr != '0), o_out.status == ST_OK && !o_out.freed_valid)

endmodule

bind two_level_page_table_manager tlptm_checker u_checker (.*);
